// ----- src/rsft_pkg.sv -----
package rsft_pkg;

   // frame length and field layout
   localparam int unsigned FRAME_BITS = 21;
   localparam int unsigned NET_BITS   = 12;
   localparam int unsigned BIT_POS_W  = 5;
   localparam int unsigned UNIT_CNT_W = 4;
   localparam int unsigned REPEAT_W   = 4;
   localparam int unsigned TPU_W      = 16;

   // register reset values
   localparam logic [TPU_W-1:0]    TICKS_PER_UNIT_RESET = 16'd670;
   localparam logic [REPEAT_W-1:0] REPEAT_COUNT_RESET   = 4'd10;

   // register indexes
   localparam logic REG_TICKS_PER_UNIT = 1'b0;
   localparam logic REG_REPEAT_COUNT   = 1'b1;

   // segment lengths in units
   localparam logic [UNIT_CNT_W-1:0] SYNC_LO_UNITS  = 4'd2;
   localparam logic [UNIT_CNT_W-1:0] SYNC_HI_UNITS  = 4'd2;
   localparam logic [UNIT_CNT_W-1:0] SYNC_GAP_UNITS = 4'd10;
   localparam logic [UNIT_CNT_W-1:0] LONG_UNITS     = 4'd2;
   localparam logic [UNIT_CNT_W-1:0] SHORT_UNITS    = 4'd1;
   localparam logic [UNIT_CNT_W-1:0] TAIL_UNITS     = 4'd5;

   // item kinds on req_tuser
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SEND = 1'b1;

   // segment phase, one-hot
   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_SYNC_LO  = 7'b0000010,
      PH_SYNC_HI  = 7'b0000100,
      PH_SYNC_GAP = 7'b0001000,
      PH_BIT_LO   = 7'b0010000,
      PH_BIT_HI   = 7'b0100000,
      PH_TAIL     = 7'b1000000
   } phase_type;

   // one result item
   typedef struct packed {
      logic done_res;
      logic busy_res;
      logic line_level;
   } result_type;

endpackage

// ----- src/rf_switch_frame_transmitter_top.sv -----
// Pulse-width remote switch transmitter. A send transaction (req_tuser = 1) taken while idle
// builds a 21-bit frame (start bit, network, address, flags, check) and starts a
// transmission; a send while busy is ignored. Each tick transaction (req_tuser = 0) advances
// time by one tick: each repeat sends a sync of low 2, high 2, low 10 units and then the frame
// MSB first (one: low 2, high 1; zero: low 1, high 2), and the line then stays low 5 units.
// One unit is ticks_per_unit ticks (0 acts as 1). Every request yields exactly one response
// with the line level of that tick and a busy flag; rsp_tlast marks the last tail tick.
// Rate: one transaction per clock cycle while req_tready is high; the response is registered,
// and the state update is a single pass through the tick and unit counters. A skid
// entry behind the output register takes one more request while a response waits, after
// which req_tready stays low until the waiting response is taken.
module rf_switch_frame_transmitter_top #(
   parameter int unsigned TICK_COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: network_id[11:0], button_address[13:12], broadcast_flag[14],
   //        onoff_flag[15], dimmer_flag[16], zero fill [23:17]
   input  logic [23:0] req_tdata,
   // tuser: command (0 tick, 1 send)
   input  logic        req_tuser,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: line_level[0], busy_res[1], zero fill [7:2]
   output logic [7:0]  rsp_tdata,
   // tlast: done_res, last tick of the trailing low period
   output logic        rsp_tlast,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned TW = TICK_COUNT_WIDTH;

   // configuration registers
   logic [rsft_pkg::TPU_W-1:0]    ticks_per_unit_ff;
   logic [rsft_pkg::REPEAT_W-1:0] repeat_count_ff;
   logic                          csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_unit_ff <= rsft_pkg::TICKS_PER_UNIT_RESET;
         repeat_count_ff   <= rsft_pkg::REPEAT_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            rsft_pkg::REG_TICKS_PER_UNIT: ticks_per_unit_ff <= csr_pwdata[15:0];
            rsft_pkg::REG_REPEAT_COUNT:   repeat_count_ff   <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      case (csr_paddr[2])
         rsft_pkg::REG_TICKS_PER_UNIT: csr_prdata = {16'd0, ticks_per_unit_ff};
         rsft_pkg::REG_REPEAT_COUNT:   csr_prdata = {28'd0, repeat_count_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // transmitter state
   logic [rsft_pkg::FRAME_BITS-1:0] frame_word_ff, frame_word_in;
   logic [rsft_pkg::REPEAT_W-1:0]   repeat_counter_ff, repeat_counter_in;
   logic [rsft_pkg::BIT_POS_W-1:0]  bit_position_ff, bit_position_in;
   rsft_pkg::phase_type             phase_ff, phase_in;
   logic [rsft_pkg::UNIT_CNT_W-1:0] unit_counter_ff, unit_counter_in;
   logic [TW-1:0]                   tick_counter_ff, tick_counter_in;

   // output buffer: main register plus skid entry
   logic                 out_valid_ff, out_valid_in;
   rsft_pkg::result_type out_data_ff, out_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsft_pkg::result_type skid_data_ff, skid_data_in;

   logic push, pop;
   assign req_tready = !skid_valid_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   // request fields
   logic [rsft_pkg::NET_BITS-1:0] net_id;
   logic [1:0]                    adr;
   logic                          bc, onf, dim;
   logic [1:0]                    chk;
   assign net_id = req_tdata[11:0];
   assign adr    = req_tdata[13:12];
   assign bc     = req_tdata[14];
   assign onf    = req_tdata[15];
   assign dim    = req_tdata[16];
   assign chk    = adr ^ {bc, onf} ^ {dim, 1'b0};

   // unit length, zero acts as one
   logic [TW-1:0] tpu_w, unit_len, tick_next;
   logic          unit_end;
   assign tpu_w     = TW'(ticks_per_unit_ff);
   assign unit_len  = (tpu_w == '0) ? TW'(1) : tpu_w;
   assign tick_next = tick_counter_ff + TW'(1);
   assign unit_end  = (tick_next >= unit_len) || (tick_next == '0);

   // current bit and segment length
   logic                            cur_bit, active, level;
   logic [rsft_pkg::UNIT_CNT_W-1:0] seg_units, unit_next;
   assign cur_bit   = frame_word_ff[bit_position_ff];
   assign active    = (phase_ff != rsft_pkg::PH_IDLE);
   assign level     = (phase_ff == rsft_pkg::PH_SYNC_HI) || (phase_ff == rsft_pkg::PH_BIT_HI);
   assign unit_next = unit_counter_ff + 4'd1;

   always_comb begin
      case (phase_ff)
         rsft_pkg::PH_SYNC_LO:  seg_units = rsft_pkg::SYNC_LO_UNITS;
         rsft_pkg::PH_SYNC_HI:  seg_units = rsft_pkg::SYNC_HI_UNITS;
         rsft_pkg::PH_SYNC_GAP: seg_units = rsft_pkg::SYNC_GAP_UNITS;
         rsft_pkg::PH_BIT_LO:
            seg_units = cur_bit ? rsft_pkg::LONG_UNITS : rsft_pkg::SHORT_UNITS;
         rsft_pkg::PH_BIT_HI:
            seg_units = cur_bit ? rsft_pkg::SHORT_UNITS : rsft_pkg::LONG_UNITS;
         rsft_pkg::PH_TAIL:     seg_units = rsft_pkg::TAIL_UNITS;
         default:               seg_units = rsft_pkg::SHORT_UNITS;
      endcase
   end

   // next state and result of the accepted transaction
   rsft_pkg::result_type res;

   always_comb begin
      frame_word_in     = frame_word_ff;
      repeat_counter_in = repeat_counter_ff;
      bit_position_in   = bit_position_ff;
      phase_in          = phase_ff;
      unit_counter_in   = unit_counter_ff;
      tick_counter_in   = tick_counter_ff;
      res.line_level    = 1'b0;
      res.busy_res      = 1'b0;
      res.done_res      = 1'b0;

      if (req_tuser == rsft_pkg::CMD_SEND) begin
         res.busy_res = 1'b1;
         res.line_level = level;
         if (!active) begin
            // load a new frame
            frame_word_in     = {1'b1, net_id, adr, bc, onf, dim, 1'b0, chk};
            repeat_counter_in = repeat_count_ff;
            bit_position_in   = '0;
            unit_counter_in   = '0;
            tick_counter_in   = '0;
            res.line_level    = 1'b0;
            phase_in = (repeat_count_ff != '0) ? rsft_pkg::PH_SYNC_LO : rsft_pkg::PH_TAIL;
         end
      end else if (active) begin
         res.busy_res   = 1'b1;
         res.line_level = level;
         tick_counter_in = tick_next;
         if (unit_end) begin
            tick_counter_in = '0;
            unit_counter_in = unit_next;
            if (unit_next >= seg_units) begin
               unit_counter_in = '0;
               // segment sequencing
               case (phase_ff)
                  rsft_pkg::PH_SYNC_LO:  phase_in = rsft_pkg::PH_SYNC_HI;
                  rsft_pkg::PH_SYNC_HI:  phase_in = rsft_pkg::PH_SYNC_GAP;
                  rsft_pkg::PH_SYNC_GAP: begin
                     phase_in        = rsft_pkg::PH_BIT_LO;
                     bit_position_in = rsft_pkg::BIT_POS_W'(rsft_pkg::FRAME_BITS - 1);
                  end
                  rsft_pkg::PH_BIT_LO:   phase_in = rsft_pkg::PH_BIT_HI;
                  rsft_pkg::PH_BIT_HI: begin
                     if (bit_position_ff != '0) begin
                        bit_position_in = bit_position_ff - 5'd1;
                        phase_in        = rsft_pkg::PH_BIT_LO;
                     end else begin
                        repeat_counter_in = repeat_counter_ff - 4'd1;
                        phase_in = (repeat_counter_ff != 4'd1) ? rsft_pkg::PH_SYNC_LO
                                                                : rsft_pkg::PH_TAIL;
                     end
                  end
                  default: begin
                     // end of tail, back to idle
                     res.done_res      = 1'b1;
                     phase_in          = rsft_pkg::PH_IDLE;
                     bit_position_in   = '0;
                     repeat_counter_in = '0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_word_ff     <= '0;
         repeat_counter_ff <= '0;
         bit_position_ff   <= '0;
         phase_ff          <= rsft_pkg::PH_IDLE;
         unit_counter_ff   <= '0;
         tick_counter_ff   <= '0;
      end else if (push) begin
         frame_word_ff     <= frame_word_in;
         repeat_counter_ff <= repeat_counter_in;
         bit_position_ff   <= bit_position_in;
         phase_ff          <= phase_in;
         unit_counter_ff   <= unit_counter_in;
         tick_counter_ff   <= tick_counter_in;
      end
   end

   // output buffer control
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_data_ff.busy_res, out_data_ff.line_level};
   assign rsp_tlast  = out_data_ff.done_res;

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_high_is_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> rsp_tdata[1])
      else $error("line high on a response that is not busy");

   a_done_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[1] && !rsp_tdata[0]))
      else $error("done response must be busy with line low");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rsft_pkg::PH_IDLE) |-> (tick_counter_ff == '0 && unit_counter_ff == '0))
      else $error("counters not cleared while idle");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_position_ff < rsft_pkg::BIT_POS_W'(rsft_pkg::FRAME_BITS))
      else $error("bit position past end of frame");

endmodule

// ----- tb/rf_switch_frame_checker.sv -----
`timescale 1ns / 100ps

// watches the request, response and register channels, predicts every line
// sample and compares each response transaction with the oldest prediction
module rf_switch_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // tdata: network_id[11:0], button_address[13:12], broadcast_flag[14],
   //        onoff_flag[15], dimmer_flag[16], zero fill [23:17]
   input  logic [23:0] req_tdata,
   // tuser: command (0 tick, 1 send)
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: line_level[0], busy_res[1], zero fill [7:2]
   input  logic [7:0]  rsp_tdata,
   // tlast: done_res
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          results_waiting,
   output int          results_seen,
   output int          frames_sent
);

   // register copies
   logic [rsft_pkg::TPU_W-1:0]      unit_ticks_cfg;
   logic [rsft_pkg::REPEAT_W-1:0]   repeats_cfg;

   // transmitter state
   logic [rsft_pkg::FRAME_BITS-1:0] frame_bits;
   logic [rsft_pkg::REPEAT_W-1:0]   repeats_left;
   logic [rsft_pkg::BIT_POS_W-1:0]  bit_index;
   rsft_pkg::phase_type             tx_phase;
   logic [rsft_pkg::UNIT_CNT_W-1:0] units_done;
   logic [rsft_pkg::TPU_W-1:0]      ticks_done;
   logic                            tx_active;

   rsft_pkg::result_type            line_samples_q[$];

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
   endtask

   function automatic void return_to_idle();
      tx_active    = 1'b0;
      tx_phase     = rsft_pkg::PH_IDLE;
      units_done   = '0;
      ticks_done   = '0;
      bit_index    = '0;
      repeats_left = '0;
   endfunction

   function automatic logic line_now();
      return tx_active && (tx_phase == rsft_pkg::PH_SYNC_HI ||
                           tx_phase == rsft_pkg::PH_BIT_HI);
   endfunction

   // length of the current segment in units; a one is long low, short high
   function automatic logic [rsft_pkg::UNIT_CNT_W-1:0] phase_units();
      case (tx_phase)
         rsft_pkg::PH_SYNC_LO:  return rsft_pkg::SYNC_LO_UNITS;
         rsft_pkg::PH_SYNC_HI:  return rsft_pkg::SYNC_HI_UNITS;
         rsft_pkg::PH_SYNC_GAP: return rsft_pkg::SYNC_GAP_UNITS;
         rsft_pkg::PH_BIT_LO:
            return frame_bits[bit_index] ? rsft_pkg::LONG_UNITS : rsft_pkg::SHORT_UNITS;
         rsft_pkg::PH_BIT_HI:
            return frame_bits[bit_index] ? rsft_pkg::SHORT_UNITS : rsft_pkg::LONG_UNITS;
         rsft_pkg::PH_TAIL:     return rsft_pkg::TAIL_UNITS;
         default:               return rsft_pkg::SHORT_UNITS;
      endcase
   endfunction

   function automatic void advance_phase();
      case (tx_phase)
         rsft_pkg::PH_SYNC_LO: tx_phase = rsft_pkg::PH_SYNC_HI;
         rsft_pkg::PH_SYNC_HI: tx_phase = rsft_pkg::PH_SYNC_GAP;
         rsft_pkg::PH_SYNC_GAP: begin
            tx_phase  = rsft_pkg::PH_BIT_LO;
            bit_index = rsft_pkg::BIT_POS_W'(rsft_pkg::FRAME_BITS - 1);
         end
         rsft_pkg::PH_BIT_LO: tx_phase = rsft_pkg::PH_BIT_HI;
         rsft_pkg::PH_BIT_HI: begin
            if (bit_index != '0) begin
               bit_index--;
               tx_phase = rsft_pkg::PH_BIT_LO;
            end else begin
               repeats_left--;
               if (repeats_left != '0)
                  tx_phase = rsft_pkg::PH_SYNC_LO;
               else
                  tx_phase = rsft_pkg::PH_TAIL;
            end
         end
         default: return_to_idle();
      endcase
   endfunction

   // one request transaction: a send loads the frame when idle, a tick moves time
   function automatic rsft_pkg::result_type transmit_step(input logic cmd,
                                                         input logic [23:0] d);
      rsft_pkg::result_type       r;
      logic [11:0]                net;
      logic [1:0]                 adr;
      logic [1:0]                 check;
      logic                       bc;
      logic                       onf;
      logic                       dim;
      logic [rsft_pkg::TPU_W-1:0] unit_len;
      r        = '0;
      net      = d[11:0];
      adr      = d[13:12];
      bc       = d[14];
      onf      = d[15];
      dim      = d[16];
      unit_len = (unit_ticks_cfg == '0) ? rsft_pkg::TPU_W'(1) : unit_ticks_cfg;
      if (cmd == rsft_pkg::CMD_SEND) begin
         if (!tx_active) begin
            check        = adr ^ {bc, onf} ^ {dim, 1'b0};
            frame_bits   = {1'b1, net, adr, bc, onf, dim, 1'b0, check};
            tx_active    = 1'b1;
            units_done   = '0;
            ticks_done   = '0;
            bit_index    = '0;
            repeats_left = repeats_cfg;
            if (repeats_cfg != '0)
               tx_phase = rsft_pkg::PH_SYNC_LO;
            else
               tx_phase = rsft_pkg::PH_TAIL;
         end
         r.line_level = line_now();
         r.busy_res   = 1'b1;
      end else if (tx_active) begin
         r.line_level = line_now();
         r.busy_res   = 1'b1;
         ticks_done++;
         // a shrunk unit length ends the unit at once
         if (ticks_done >= unit_len || ticks_done == '0) begin
            ticks_done = '0;
            units_done++;
            if (units_done >= phase_units()) begin
               units_done = '0;
               if (tx_phase == rsft_pkg::PH_TAIL)
                  r.done_res = 1'b1;
               advance_phase();
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsft_pkg::result_type want;
      rsft_pkg::result_type got;
      logic [31:0]          reg_value;
      if (reset) begin
         unit_ticks_cfg = rsft_pkg::TICKS_PER_UNIT_RESET;
         repeats_cfg    = rsft_pkg::REPEAT_COUNT_RESET;
         frame_bits     = '0;
         return_to_idle();
         line_samples_q.delete();
         mismatch_count = 0;
         results_seen   = 0;
         frames_sent    = 0;
      end else begin
         // register writes and read-back
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[2])
                  rsft_pkg::REG_TICKS_PER_UNIT:
                     unit_ticks_cfg = csr_pwdata[rsft_pkg::TPU_W-1:0];
                  rsft_pkg::REG_REPEAT_COUNT:
                     repeats_cfg    = csr_pwdata[rsft_pkg::REPEAT_W-1:0];
                  default: ;
               endcase
            end else begin
               if (csr_paddr[2] == rsft_pkg::REG_TICKS_PER_UNIT)
                  reg_value = 32'(unit_ticks_cfg);
               else
                  reg_value = 32'(repeats_cfg);
               if (csr_prdata !== reg_value)
                  note_mismatch("register read", reg_value, csr_prdata);
            end
         end

         // response transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = rsft_pkg::result_type'({rsp_tlast, rsp_tdata[1:0]});
            if (line_samples_q.size() == 0) begin
               note_mismatch("response with nothing expected", '0, 32'(rsp_tdata));
            end else begin
               want = line_samples_q.pop_front();
               if (got.line_level !== want.line_level)
                  note_mismatch("line_level", 32'(want.line_level), 32'(got.line_level));
               if (got.busy_res !== want.busy_res)
                  note_mismatch("busy_res", 32'(want.busy_res), 32'(got.busy_res));
               if (got.done_res !== want.done_res)
                  note_mismatch("done_res", 32'(want.done_res), 32'(got.done_res));
            end
         end

         // request transaction
         if (req_tvalid && req_tready) begin
            want = transmit_step(req_tuser, req_tdata);
            if (want.done_res)
               frames_sent++;
            line_samples_q.push_back(want);
         end
      end
      results_waiting = line_samples_q.size();
   end

endmodule

// ----- tb/tb_rf_switch_frame_transmitter_top.sv -----
`timescale 1ns / 100ps

module tb_rf_switch_frame_transmitter_top;

   localparam logic [2:0] TPU_ADDR = {rsft_pkg::REG_TICKS_PER_UNIT, 2'b00};
   localparam logic [2:0] REP_ADDR = {rsft_pkg::REG_REPEAT_COUNT, 2'b00};
   localparam int TOTAL_ITEMS      = 1650;
   localparam int QUIET_ITEMS      = 200;
   localparam int CYCLE_LIMIT      = 600000;
   // sync is 14 units, each of the 21 bits 3 units
   localparam int UNITS_PER_REPEAT = 77;
   localparam int TAIL_LEN         = 5;
   localparam int DRAIN_PAD        = 4;
   localparam int LONG_STALL       = 300;
   localparam int STALL_REPEATS    = 3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // tdata: network_id[11:0], button_address[13:12], broadcast_flag[14],
   //        onoff_flag[15], dimmer_flag[16], zero fill [23:17]
   logic [23:0] req_tdata;
   // tuser: command (0 tick, 1 send)
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // tdata: line_level[0], busy_res[1], zero fill [7:2]
   logic [7:0]  rsp_tdata;
   // tlast: done_res
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int results_waiting;
   int results_seen;
   int frames_sent;
   int cycle_count  = 0;
   int items_sent   = 0;
   int stalls_asked = 0;
   bit gaps_on      = 1'b1;

   rf_switch_frame_transmitter_top DUT (.*);

   rf_switch_frame_checker frame_check (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin : rsp_side
      int stalls_done;
      stalls_done = 0;
      rsp_tready  = 1'b0;
      forever begin
         if (stalls_asked != stalls_done) begin
            stalls_done++;
            rsp_tready <= 1'b0;
            for (int n = 0; n < LONG_STALL; n++)
               @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic logic [23:0] rand_fields();
      return {7'b0, 17'($urandom)};
   endfunction

   // one request transaction, valid left high for a following one
   task automatic put_item(input logic cmd, input logic [23:0] data);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_frame(input logic [11:0] net, input logic [1:0] adr,
                             input logic bc, input logic onf, input logic dim);
      put_item(rsft_pkg::CMD_SEND, {7'b0, dim, onf, bc, adr, net});
   endtask

   task automatic run_ticks(input int count);
      repeat (count) put_item(rsft_pkg::CMD_TICK, rand_fields());
   endtask

   // stop offering and wait for every response
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0)
         @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr,
                             input logic [31:0] wdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write, then read back
   task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
      csr_access(1'b1, addr, value);
      csr_access(1'b0, addr, '0);
   endtask

   initial begin : stimulus
      int          span;
      logic [15:0] tpu_pick;
      logic [3:0]  rep_pick;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = rsft_pkg::CMD_TICK;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle tick, send with every field at its top, send while busy
      put_item(rsft_pkg::CMD_TICK, rand_fields());
      send_frame(12'hFFF, 2'd3, 1'b1, 1'b1, 1'b1);
      send_frame(12'h000, 2'd0, 1'b0, 1'b0, 1'b0);
      run_ticks(12);

      // longest unit, then shrink the unit in the middle of a transmission
      wait_drained();
      set_register(TPU_ADDR, 32'h0000_FFFF);
      run_ticks(6);
      wait_drained();
      set_register(TPU_ADDR, 32'd1);
      run_ticks(UNITS_PER_REPEAT * int'(rsft_pkg::REPEAT_COUNT_RESET) + TAIL_LEN + 4);

      // zero unit length and zero repeats: trailing low only
      wait_drained();
      set_register(TPU_ADDR, 32'd0);
      set_register(REP_ADDR, 32'd0);
      send_frame(12'h000, 2'd0, 1'b0, 1'b0, 1'b0);
      run_ticks(TAIL_LEN + 3);

      // several repeats, with a long output stall while ticks keep coming
      wait_drained();
      set_register(REP_ADDR, 32'(STALL_REPEATS));
      send_frame(12'h5A5, 2'd2, 1'b0, 1'b1, 1'b0);
      run_ticks(20);
      stalls_asked++;
      run_ticks(UNITS_PER_REPEAT * STALL_REPEATS + TAIL_LEN);

      // random frames at small unit lengths, with some unstructured noise
      while (items_sent < TOTAL_ITEMS) begin
         wait_drained();
         gaps_on = (TOTAL_ITEMS - items_sent > QUIET_ITEMS) &&
                   ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       tpu_pick = 16'd0;
            9:       tpu_pick = 16'($urandom_range(2, 4));
            default: tpu_pick = 16'd1;
         endcase
         rep_pick = 4'($urandom_range(0, 2));
         span = (UNITS_PER_REPEAT * int'(rep_pick) + TAIL_LEN) *
                ((tpu_pick == 16'd0) ? 1 : int'(tpu_pick));
         // keep the last frames within the item budget
         if (span > TOTAL_ITEMS - items_sent) begin
            tpu_pick = 16'd1;
            rep_pick = 4'd0;
            span     = TAIL_LEN;
         end
         set_register(TPU_ADDR, {16'($urandom), tpu_pick});
         set_register(REP_ADDR, {28'($urandom), rep_pick});
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(5, 30))
               put_item(1'($urandom_range(0, 1)), rand_fields());
         end else begin
            run_ticks($urandom_range(0, 3));
            put_item(rsft_pkg::CMD_SEND, rand_fields());
            for (int i = 0; i < span; i++) begin
               if ($urandom_range(0, 15) == 0)
                  put_item(rsft_pkg::CMD_SEND, rand_fields());
               put_item(rsft_pkg::CMD_TICK, rand_fields());
            end
            run_ticks($urandom_range(0, 4));
         end
      end

      // drain and give the verdict
      gaps_on = 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      $display("%0d request and %0d response transactions, %0d frames completed",
               items_sent, results_seen, frames_sent);
      $display("units of 0, 1, few and 65535 ticks; 0 to 10 repeats; sends while busy;");
      $display("a long output stall with the input backed up");
      if (mismatch_count == 0 && results_waiting == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count, results_waiting);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
